/* rtl/core/sspf_pkg.sv */
// ----------------------------------------------------------------------------
// sspf_pkg: shared types and constants of the SSH packet framer
// Holds the queue entry layout, the entry kind codes and the padding
// generator step used by the front and back parts of the framer.
// ----------------------------------------------------------------------------
package sspf_pkg;

    // Input transaction layout: payload_byte, byte_count, seed, zero fill.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 8;

    // Command queue between the front and the back part.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Entry kinds.
    localparam logic [1:0] KIND_ERR   = 2'd0;
    localparam logic [1:0] KIND_FIRST = 2'd1;
    localparam logic [1:0] KIND_NEXT  = 2'd2;

    localparam logic [31:0] PAD_DEFAULT_SEED = 32'h4E59_4E31;
    localparam logic [3:0]  PAD_MIN          = 4'd4;
    localparam logic [3:0]  HDR_LAST         = 4'd4;

    typedef struct packed {
        logic [1:0]  kind;
        logic        last;   // last payload byte of the packet
        logic [7:0]  data;
        logic [11:0] len;
        logic [3:0]  pad;
        logic [31:0] seed;   // zero seed already replaced by the default
    } sspf_entry_t;

    // One xorshift (13,17,5) step.
    function automatic logic [31:0] xorshift_step(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

endpackage

/* rtl/core/sspf_front.sv */
// ----------------------------------------------------------------------------
// sspf_front: input side of the SSH packet framer
// Accepts payload transactions, tracks the packet boundary, checks the
// length on a first byte and pushes one classified command per transaction.
// ----------------------------------------------------------------------------
module sspf_front #(
    parameter int MAX_PACKET = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sspf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                q_full,
    output logic                                q_push,
    output sspf_pkg::sspf_entry_t               q_entry
);

    localparam logic [12:0] LEN_LIMIT = 13'(MAX_PACKET - 32);

    logic [11:0] bytes_left_reg;
    logic [11:0] bytes_left_next;
    logic [3:0]  pad_reg;
    logic [3:0]  pad_next;

    logic [7:0]  pbyte;
    logic [11:0] plen;
    logic [31:0] sd;
    logic        len_bad;
    logic [2:0]  len_mod;
    logic [3:0]  pad_calc;

    function automatic logic [3:0] PAD_MIN_ADD(input logic [2:0] m);
        logic [2:0] neg;
        neg = 3'(3'd0 - m);
        return 4'(sspf_pkg::PAD_MIN + {1'b0, neg});
    endfunction

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    assign pbyte = s_axis_tdata[7:0];
    assign plen  = s_axis_tdata[19:8];
    assign sd    = s_axis_tdata[51:20];

    always_comb
    begin
        len_bad  = (plen == 12'd0) || ({1'b0, plen} > LEN_LIMIT);
        // Header and length byte add 5, so pad up from len + 9 modulo 8.
        len_mod  = 3'(plen[2:0] + 3'd1);
        pad_calc = PAD_MIN_ADD(len_mod);

        bytes_left_next = bytes_left_reg;
        pad_next        = pad_reg;
        q_entry.kind    = sspf_pkg::KIND_NEXT;
        q_entry.last    = 1'b0;
        q_entry.data    = pbyte;
        q_entry.len     = plen;
        q_entry.pad     = pad_reg;
        q_entry.seed    = (sd == 32'd0) ? sspf_pkg::PAD_DEFAULT_SEED : sd;

        if (bytes_left_reg == 12'd0)
        begin
            if (len_bad)
            begin
                q_entry.kind = sspf_pkg::KIND_ERR;
            end
            else
            begin
                q_entry.kind    = sspf_pkg::KIND_FIRST;
                q_entry.last    = (plen == 12'd1);
                q_entry.pad     = pad_calc;
                bytes_left_next = 12'(plen - 12'd1);
                pad_next        = pad_calc;
            end
        end
        else
        begin
            q_entry.last    = (bytes_left_reg == 12'd1);
            bytes_left_next = 12'(bytes_left_reg - 12'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= 12'd0;
            pad_reg        <= 4'd0;
        end
        else if (q_push)
        begin
            bytes_left_reg <= bytes_left_next;
            pad_reg        <= pad_next;
        end
    end

endmodule

/* rtl/core/sspf_queue.sv */
// ----------------------------------------------------------------------------
// sspf_queue: command queue of the SSH packet framer
// A short first-in first-out buffer that decouples the front and back parts.
// ----------------------------------------------------------------------------
module sspf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  sspf_pkg::sspf_entry_t   push_entry,
    input  logic                    pop,
    output logic                    full,
    output logic                    head_valid,
    output sspf_pkg::sspf_entry_t   head_entry
);

    sspf_pkg::sspf_entry_t slot_reg [sspf_pkg::QDEPTH];

    logic [sspf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sspf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sspf_pkg::QCNT_W-1:0] count_reg;
    logic [sspf_pkg::QCNT_W-1:0] count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full       = (count_reg == sspf_pkg::QCNT_W'(sspf_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = sspf_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = sspf_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= sspf_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= sspf_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/sspf_back.sv */
// ----------------------------------------------------------------------------
// sspf_back: output sequencer of the SSH packet framer
// Expands each queued command into header, payload and padding bytes and
// holds them in the output register until the sink takes them.
// ----------------------------------------------------------------------------
module sspf_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                head_valid,
    input  sspf_pkg::sspf_entry_t               head_entry,
    output logic                                q_pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sspf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [0:0]                          m_axis_tuser
);

    localparam logic [1:0] PH_NEW = 2'd0;
    localparam logic [1:0] PH_HDR = 2'd1;
    localparam logic [1:0] PH_PAY = 2'd2;
    localparam logic [1:0] PH_PAD = 2'd3;

    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic [31:0] rng_reg;
    logic [31:0] rng_next;
    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        last_reg;
    logic        last_next;
    logic        bad_reg;
    logic        bad_next;

    logic        step;
    logic        emit_payload;
    logic [12:0] plen;
    logic [31:0] rng_step;

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = byte_reg;
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = bad_reg;

    assign step     = head_valid && (!valid_reg || m_axis_tready);
    // Packet length is below 2^13, so its two upper bytes are zero.
    assign plen     = 13'(13'd1 + {1'b0, head_entry.len} + {9'd0, head_entry.pad});
    assign rng_step = sspf_pkg::xorshift_step(rng_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        rng_next     = rng_reg;
        valid_next   = valid_reg && !m_axis_tready;
        byte_next    = byte_reg;
        last_next    = last_reg;
        bad_next     = bad_reg;
        q_pop        = 1'b0;
        emit_payload = 1'b0;

        if (step)
        begin
            valid_next = 1'b1;
            byte_next  = 8'd0;
            last_next  = 1'b0;
            bad_next   = 1'b0;
            unique case (phase_reg)
                PH_NEW:
                begin
                    unique case (head_entry.kind)
                        sspf_pkg::KIND_ERR:
                        begin
                            bad_next = 1'b1;
                            q_pop    = 1'b1;
                        end
                        sspf_pkg::KIND_FIRST:
                        begin
                            // First length byte is always zero.
                            cnt_next   = 4'd1;
                            phase_next = PH_HDR;
                            rng_next   = head_entry.seed;
                        end
                        default:
                        begin
                            emit_payload = 1'b1;
                        end
                    endcase
                end
                PH_HDR:
                begin
                    case (cnt_reg)
                        4'd2:    byte_next = {3'd0, plen[12:8]};
                        4'd3:    byte_next = plen[7:0];
                        4'd4:    byte_next = {4'd0, head_entry.pad};
                        default: byte_next = 8'd0;
                    endcase
                    if (cnt_reg == sspf_pkg::HDR_LAST)
                    begin
                        phase_next = PH_PAY;
                    end
                    else
                    begin
                        cnt_next = 4'(cnt_reg + 4'd1);
                    end
                end
                PH_PAY:
                begin
                    emit_payload = 1'b1;
                end
                default:
                begin
                    byte_next = rng_step[7:0];
                    rng_next  = rng_step;
                    cnt_next  = 4'(cnt_reg - 4'd1);
                    if (cnt_reg == 4'd1)
                    begin
                        last_next  = 1'b1;
                        q_pop      = 1'b1;
                        phase_next = PH_NEW;
                    end
                end
            endcase

            if (emit_payload)
            begin
                byte_next = head_entry.data;
                if (head_entry.last)
                begin
                    phase_next = PH_PAD;
                    cnt_next   = head_entry.pad;
                end
                else
                begin
                    q_pop      = 1'b1;
                    phase_next = PH_NEW;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NEW;
            cnt_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rng_reg  <= rng_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        bad_reg  <= bad_next;
    end

endmodule

/* rtl/core/secure_shell_packet_framer_unit.sv */
// Path: an accepted payload transaction goes through the command queue to the back sequencer and its output register.
// Throughput: one payload byte per cycle inside a packet while the queue holds entries and the
// sink takes bytes; the first byte of a packet is preceded by five header bytes, and the last
// byte is followed by its padding bytes (4 to 11).
// Reset: rst_n clears the packet tracking, the command queue and the output valid.
// ----------------------------------------------------------------------------
// secure_shell_packet_framer_unit: SSH binary packet framer, sender side
// Frames a payload byte stream into the unencrypted SSH binary packet layout:
// a 4-byte big-endian packet length, a padding-length byte, the payload and
// 4 to 11 xorshift padding bytes so the frame is a multiple of 8 bytes.
// ----------------------------------------------------------------------------
module secure_shell_packet_framer_unit #(
    parameter int MAX_PACKET = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input transaction: one payload byte; length and seed are read on the
    // first byte of a packet only.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0: payload_byte[7:0], byte_count[19:8], seed[51:20],
    // zero fill [55:52].
    input  logic [sspf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output transaction: one byte of the framed packet.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0: out_byte[7:0].
    output logic [sspf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tlast: end_of_packet, high on the final padding byte.
    output logic                                m_axis_tlast,
    // tuser from bit 0: bad_length[0], high on a rejected length transaction.
    output logic [0:0]                          m_axis_tuser
);

    // The front part classifies each accepted transaction as a rejected
    // length, the first byte of a packet or a following byte, and it
    // tracks how many payload bytes of the packet are still to come.
    sspf_pkg::sspf_entry_t push_entry;
    sspf_pkg::sspf_entry_t head_entry;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  head_valid;

    sspf_front #(
        .MAX_PACKET (MAX_PACKET)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (push_entry)
    );

    // The queue lets the input keep flowing while the back part spends
    // extra cycles on header and padding bytes.
    sspf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // The back part walks each command through its output bytes and
    // releases the queue entry with the last byte that the command causes.
    sspf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* bench/tb_secure_shell_packet_framer_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_secure_shell_packet_framer_unit: self-checking bench of the SSH framer
// Streams payload bytes into the framer and predicts every framed byte.
// The prediction covers the length header, the padding length, the payload
// and the xorshift padding. Each output transaction is compared field by
// field with the oldest prediction. Both sides idle at random, and the
// receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
module tb_secure_shell_packet_framer_unit;

    localparam int MAX_PACKET   = 4096;
    localparam int MAX_PAYLOAD  = MAX_PACKET - 32;
    localparam int RANDOM_ITEMS = 400;
    localparam int STALL_LIMIT  = 5000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam logic [31:0] DEFAULT_SEED = 32'h4E59_4E31;

    // One input transaction as seen by the framer.
    typedef struct packed {
        logic [7:0]  data;
        logic [11:0] len;
        logic [31:0] seed;
    } payload_item_t;

    // One framed byte on the wire.
    typedef struct packed {
        logic [7:0] data;
        logic       eop;
        logic       bad;
    } wire_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [sspf_pkg::IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [sspf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                                m_axis_tlast;
    logic [0:0]                          m_axis_tuser;

    // Items waiting to be offered; the front is the one on the bus while valid.
    payload_item_t pending_bytes[$];
    // Framed bytes predicted but not yet seen at the output.
    wire_byte_t    expected_wire[$];

    // Predictor state: payload bytes still due, padding length and generator.
    logic [11:0] left_bytes = '0;
    logic [3:0]  pad_len = '0;
    logic [31:0] pad_state = '0;

    int items_sent = 0;
    int phase1_start = 0;
    int phase2_start = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    secure_shell_packet_framer_unit #(
        .MAX_PACKET(MAX_PACKET)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Three idling regimes, chosen by how many input transactions went in:
    // sender idles lightly and receiver heavily, then the reverse, then none.
    function automatic int phase_of(input int sent);
        if (sent < phase1_start)
        begin
            return 0;
        end
        if (sent < phase2_start)
        begin
            return 1;
        end
        return 2;
    endfunction

    function automatic logic [31:0] xorshift_next(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    // Works out the framed bytes caused by one accepted payload transaction.
    task automatic frame_payload_byte(input payload_item_t it);
        logic [31:0] neg;
        logic [3:0]  pad;
        logic [31:0] plen;
        wire_byte_t  wb;
        if (left_bytes == 12'd0)
        begin
            // A zero length or one beyond the size limit gives a single error
            // byte, and the payload byte is dropped.
            if (it.len == 12'd0 || it.len > MAX_PAYLOAD)
            begin
                wb = '{data: 8'h00, eop: 1'b0, bad: 1'b1};
                expected_wire.push_back(wb);
                return;
            end
            // Smallest padding of at least four that makes the frame a
            // multiple of eight bytes (four length bytes, one pad byte).
            neg = 32'd0 - ({20'd0, it.len} + 32'd9);
            pad = 4'd4 + {1'b0, neg[2:0]};
            plen = 32'd1 + {20'd0, it.len} + {28'd0, pad};
            pad_len = pad;
            pad_state = (it.seed != 32'd0) ? it.seed : DEFAULT_SEED;
            left_bytes = it.len;
            expected_wire.push_back('{data: plen[31:24], eop: 1'b0, bad: 1'b0});
            expected_wire.push_back('{data: plen[23:16], eop: 1'b0, bad: 1'b0});
            expected_wire.push_back('{data: plen[15:8], eop: 1'b0, bad: 1'b0});
            expected_wire.push_back('{data: plen[7:0], eop: 1'b0, bad: 1'b0});
            expected_wire.push_back('{data: {4'd0, pad}, eop: 1'b0, bad: 1'b0});
        end
        expected_wire.push_back('{data: it.data, eop: 1'b0, bad: 1'b0});
        left_bytes = left_bytes - 12'd1;
        if (left_bytes == 12'd0)
        begin
            for (int i = 0; i < pad_len; i++)
            begin
                pad_state = xorshift_next(pad_state);
                wb = '{data: pad_state[7:0], eop: (i + 1 == pad_len), bad: 1'b0};
                expected_wire.push_back(wb);
            end
        end
    endtask

    // Queues one packet. Only the first byte carries a meaningful length and
    // seed; the later bytes carry random values that the framer must ignore.
    task automatic queue_packet(input int len, input logic [31:0] seed);
        payload_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.data = 8'($urandom);
            it.len  = (i == 0) ? 12'(len) : 12'($urandom);
            it.seed = (i == 0) ? seed : $urandom;
            pending_bytes.push_back(it);
        end
    endtask

    task automatic queue_rejected(input logic [11:0] len);
        payload_item_t it;
        it.data = 8'($urandom);
        it.len  = len;
        it.seed = $urandom;
        pending_bytes.push_back(it);
    endtask

    // Stimulus: a directed opening, then random packets whose lengths are
    // trimmed so that the random part stays within its item budget.
    initial
    begin
        int count;
        int len;
        logic [31:0] seed;
        payload_item_t it;

        // Rejected lengths: zero, all ones and one past the limit.
        queue_rejected(12'd0);
        queue_rejected(12'hFFF);
        queue_rejected(12'(MAX_PAYLOAD + 1));
        // Single-byte packets: zero seed selects the default, then an all-ones
        // seed with an all-ones byte.
        it = '{data: 8'h00, len: 12'd1, seed: 32'd0};
        pending_bytes.push_back(it);
        it = '{data: 8'hFF, len: 12'd1, seed: 32'hFFFF_FFFF};
        pending_bytes.push_back(it);
        // Mid-packet bytes with a zero and an out-of-range length, both ignored.
        it = '{data: 8'hA5, len: 12'd3, seed: 32'h1234_5678};
        pending_bytes.push_back(it);
        it = '{data: 8'h5A, len: 12'd0, seed: 32'd0};
        pending_bytes.push_back(it);
        it = '{data: 8'h3C, len: 12'hFFF, seed: 32'hFFFF_FFFF};
        pending_bytes.push_back(it);
        // Shortest padding (four bytes) and longest padding (eleven bytes).
        queue_packet(7, $urandom);
        queue_packet(8, $urandom);

        count = 0;
        while (count < RANDOM_ITEMS)
        begin
            if ($urandom_range(99) < 10)
            begin
                // Noise: a rejected first byte.
                queue_rejected(($urandom_range(1) == 0) ? 12'd0 :
                               12'($urandom_range(4095, MAX_PAYLOAD + 1)));
                count++;
            end
            else
            begin
                len = ($urandom_range(99) < 5) ? $urandom_range(300, 41) :
                                                 $urandom_range(40, 1);
                if (len > RANDOM_ITEMS - count)
                begin
                    len = RANDOM_ITEMS - count;
                end
                seed = ($urandom_range(99) < 10) ? 32'd0 : $urandom;
                queue_packet(len, seed);
                count += len;
            end
        end
        phase1_start = pending_bytes.size() / 3;
        phase2_start = 2 * pending_bytes.size() / 3;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_wire.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Driver: the front of the pending queue is held on the bus until the
    // framer takes it. Each accepted transaction feeds the predictor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            int idle_pct;
            int sent;
            sent = items_sent;
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame_payload_byte(pending_bytes[0]);
                void'(pending_bytes.pop_front());
                sent++;
                items_sent <= sent;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                case (phase_of(sent))
                    0: idle_pct = 20;
                    1: idle_pct = 73;
                    default: idle_pct = 0;
                endcase
                if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {4'd0, pending_bytes[0].seed,
                                      pending_bytes[0].len, pending_bytes[0].data};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver: checks each output transaction against the oldest
    // prediction and decides tready for the next cycle. Once the last regime
    // starts, the receiver holds off long enough for the framer to fill up
    // and stall its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            int idle_pct;
            wire_byte_t want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_wire.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected output: expected nothing, %s %h eop %b bad %b",
                             $time, "got byte", m_axis_tdata, m_axis_tlast,
                             m_axis_tuser[0]);
                end
                else
                begin
                    want = expected_wire.pop_front();
                    if (m_axis_tdata !== want.data || m_axis_tlast !== want.eop ||
                        m_axis_tuser[0] !== want.bad)
                    begin
                        mismatches++;
                        $display("%0t: mismatch: expected byte %h eop %b bad %b, %s",
                                 $time, want.data, want.eop, want.bad, "actual");
                        $display("%0t:           actual byte %h eop %b bad %b",
                                 $time, m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
                    end
                end
            end

            if (!hold_done && phase_of(items_sent) == 2)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (phase_of(items_sent))
                    0: idle_pct = 73;
                    1: idle_pct = 20;
                    default: idle_pct = 0;
                endcase
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // Watchdog: counts consecutive cycles in which no transaction happens on
    // either side.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
